// File: src/dsu_pkg.sv
// Shared types and state codes for the disjoint-set union engine.
// No dependencies; used by the top level and by the port checker.
package dsu_pkg;

  localparam int ID_W  = 10;
  localparam int CNT_W = 11;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_CLEAR  = 10'b00_0000_0010,
    ST_FIND_A = 10'b00_0000_0100,
    ST_COMP_A = 10'b00_0000_1000,
    ST_FIND_B = 10'b00_0001_0000,
    ST_COMP_B = 10'b00_0010_0000,
    ST_SIZE_A = 10'b00_0100_0000,
    ST_SIZE_B = 10'b00_1000_0000,
    ST_LINK   = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_e;

endpackage

// File: src/dsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/disjoint_set_union_engine.sv
// Disjoint-set union engine: union by size with full path compression.
// The block takes one edge at a time, through the single parent RAM port pair: it walks
// each endpoint to its root and compresses that path, reads both root sizes, then links.
// An edge with an id outside the vertex count skips the walk and gives a zero-size result;
// a stalled result holds the block until it is taken.
// After reset and after every vertex_count write a clearing pass over all MAX_VERTICES
// entries rebuilds the parent and size RAMs while no request is accepted.
module disjoint_set_union_engine #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dsu_pkg::id_t       first_vertex_i,
  input  dsu_pkg::id_t       second_vertex_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               merged_o,
  output dsu_pkg::id_t       set_root_o,
  output dsu_pkg::cnt_t      set_size_o,
  output dsu_pkg::cnt_t      components_left_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  dsu_pkg::cnt_t      vertex_count_i
);

  localparam int AW       = $clog2(MAX_VERTICES);
  localparam int SW       = $clog2(MAX_VERTICES + 1);
  localparam int VC_RESET = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;

  typedef logic [AW-1:0] addr_t;
  typedef logic [SW-1:0] size_t;

  localparam addr_t LAST_ADDR = addr_t'(MAX_VERTICES - 1);

  dsu_pkg::state_e state_q, state_d;
  dsu_pkg::cnt_t   vc_q, vc_d;
  dsu_pkg::cnt_t   comp_q, comp_d;
  addr_t           clr_q, clr_d;
  addr_t           a_q, a_d;
  addr_t           b_q, b_d;
  addr_t           cur_q, cur_d;
  addr_t           ra_q, ra_d;
  addr_t           rb_q, rb_d;
  size_t           sza_q, sza_d;
  logic            res_merged_q, res_merged_d;
  dsu_pkg::id_t    res_root_q, res_root_d;
  dsu_pkg::cnt_t   res_size_q, res_size_d;
  dsu_pkg::cnt_t   res_comp_q, res_comp_d;

  logic            out_valid_q, out_valid_d;
  logic            out_merged_q;
  dsu_pkg::id_t    out_root_q;
  dsu_pkg::cnt_t   out_size_q;
  dsu_pkg::cnt_t   out_comp_q;

  logic            p_we;
  addr_t           p_waddr, p_wdata, p_raddr, p_rdata;
  logic            s_we;
  addr_t           s_waddr, s_raddr;
  size_t           s_wdata, s_rdata;

  logic            in_accept;
  logic            in_range;
  logic            out_free;
  logic            out_load;
  dsu_pkg::cnt_t   cfg_clamped;
  size_t           size_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != dsu_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_range    = (dsu_pkg::cnt_t'(first_vertex_i) < vc_q) &&
                       (dsu_pkg::cnt_t'(second_vertex_i) < vc_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == dsu_pkg::ST_EMIT) && out_free;
  assign size_sum    = sza_q + s_rdata;

  // A zero count is taken as one vertex; a count beyond the store is capped.
  always_comb begin
    if (vertex_count_i == '0) begin
      cfg_clamped = dsu_pkg::cnt_t'(1);
    end else if (32'(vertex_count_i) > 32'(MAX_VERTICES)) begin
      cfg_clamped = dsu_pkg::cnt_t'(MAX_VERTICES);
    end else begin
      cfg_clamped = vertex_count_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    vc_d         = vc_q;
    comp_d       = comp_q;
    clr_d        = clr_q;
    a_d          = a_q;
    b_d          = b_q;
    cur_d        = cur_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    sza_d        = sza_q;
    res_merged_d = res_merged_q;
    res_root_d   = res_root_q;
    res_size_d   = res_size_q;
    res_comp_d   = res_comp_q;
    p_we         = 1'b0;
    p_waddr      = cur_q;
    p_wdata      = ra_q;
    p_raddr      = cur_q;
    s_we         = 1'b0;
    s_waddr      = ra_q;
    s_wdata      = size_sum;
    s_raddr      = ra_q;

    unique case (state_q)
      dsu_pkg::ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        s_we    = 1'b1;
        s_waddr = clr_q;
        s_wdata = size_t'(1);
        clr_d   = clr_q + addr_t'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = dsu_pkg::ST_IDLE;
        end
      end
      dsu_pkg::ST_IDLE: begin
        if (in_accept) begin
          a_d = addr_t'(first_vertex_i);
          b_d = addr_t'(second_vertex_i);
          if (in_range) begin
            cur_d   = addr_t'(first_vertex_i);
            p_raddr = addr_t'(first_vertex_i);
            state_d = dsu_pkg::ST_FIND_A;
          end else begin
            res_merged_d = 1'b0;
            res_root_d   = '0;
            res_size_d   = '0;
            res_comp_d   = comp_q;
            state_d      = dsu_pkg::ST_EMIT;
          end
        end
      end
      dsu_pkg::ST_FIND_A: begin
        if (p_rdata == cur_q) begin
          ra_d = cur_q;
          if (a_q == cur_q) begin
            cur_d   = b_q;
            p_raddr = b_q;
            state_d = dsu_pkg::ST_FIND_B;
          end else begin
            cur_d   = a_q;
            p_raddr = a_q;
            state_d = dsu_pkg::ST_COMP_A;
          end
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      dsu_pkg::ST_COMP_A: begin
        p_we    = 1'b1;
        p_wdata = ra_q;
        if (p_rdata == ra_q) begin
          cur_d   = b_q;
          p_raddr = b_q;
          state_d = dsu_pkg::ST_FIND_B;
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      dsu_pkg::ST_FIND_B: begin
        if (p_rdata == cur_q) begin
          rb_d = cur_q;
          if (b_q == cur_q) begin
            state_d = dsu_pkg::ST_SIZE_A;
          end else begin
            cur_d   = b_q;
            p_raddr = b_q;
            state_d = dsu_pkg::ST_COMP_B;
          end
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      dsu_pkg::ST_COMP_B: begin
        p_we    = 1'b1;
        p_wdata = rb_q;
        if (p_rdata == rb_q) begin
          state_d = dsu_pkg::ST_SIZE_A;
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      dsu_pkg::ST_SIZE_A: begin
        s_raddr = ra_q;
        state_d = dsu_pkg::ST_SIZE_B;
      end
      dsu_pkg::ST_SIZE_B: begin
        s_raddr = rb_q;
        sza_d   = s_rdata;
        state_d = dsu_pkg::ST_LINK;
      end
      dsu_pkg::ST_LINK: begin
        // Here s_rdata holds the size of the second root.
        if (ra_q == rb_q) begin
          res_merged_d = 1'b0;
          res_root_d   = dsu_pkg::id_t'(ra_q);
          res_size_d   = dsu_pkg::cnt_t'(sza_q);
          res_comp_d   = comp_q;
        end else begin
          if (sza_q < s_rdata) begin
            p_waddr    = ra_q;
            p_wdata    = rb_q;
            s_waddr    = rb_q;
            res_root_d = dsu_pkg::id_t'(rb_q);
          end else begin
            p_waddr    = rb_q;
            p_wdata    = ra_q;
            s_waddr    = ra_q;
            res_root_d = dsu_pkg::id_t'(ra_q);
          end
          p_we         = 1'b1;
          s_we         = 1'b1;
          s_wdata      = size_sum;
          comp_d       = (comp_q > dsu_pkg::cnt_t'(1)) ? comp_q - dsu_pkg::cnt_t'(1) : comp_q;
          res_merged_d = 1'b1;
          res_size_d   = dsu_pkg::cnt_t'(size_sum);
          res_comp_d   = comp_d;
        end
        state_d = dsu_pkg::ST_EMIT;
      end
      dsu_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = dsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsu_pkg::ST_IDLE;
      end
    endcase

    // A new vertex count rebuilds the whole structure.
    if (cfg_valid_i && cfg_ready_o) begin
      vc_d    = cfg_clamped;
      comp_d  = cfg_clamped;
      clr_d   = '0;
      state_d = dsu_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsu_pkg::ST_CLEAR;
      vc_q        <= dsu_pkg::cnt_t'(VC_RESET);
      comp_q      <= dsu_pkg::cnt_t'(VC_RESET);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      comp_q      <= comp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    cur_q        <= cur_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    sza_q        <= sza_d;
    res_merged_q <= res_merged_d;
    res_root_q   <= res_root_d;
    res_size_q   <= res_size_d;
    res_comp_q   <= res_comp_d;
    if (out_load) begin
      out_merged_q <= res_merged_q;
      out_root_q   <= res_root_q;
      out_size_q   <= res_size_q;
      out_comp_q   <= res_comp_q;
    end
  end

  dsu_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_VERTICES)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  dsu_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_VERTICES)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign merged_o          = out_merged_q;
  assign set_root_o        = out_root_q;
  assign set_size_o        = out_size_q;
  assign components_left_o = out_comp_q;

endmodule

// File: src/dsu_checker.sv
// Port-level checker for the disjoint-set union engine, attached by bind.
// Depends on dsu_pkg for the field types.
module dsu_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic          merged_o,
  input dsu_pkg::id_t  set_root_o,
  input dsu_pkg::cnt_t set_size_o,
  input dsu_pkg::cnt_t components_left_o,
  input logic          cfg_valid_i,
  input logic          cfg_ready_o
);

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(merged_o) &&
    $stable(set_root_o) && $stable(set_size_o) && $stable(components_left_o))
    else $error("result changed while stalled");

  // One request at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while the previous one is in flight");

  // A count write starts the clearing pass, which refuses requests.
  a_clear_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("request accepted during the clearing pass");

  // The zero size marks a rejected edge, which never merges.
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (set_size_o == '0) |-> !merged_o && (set_root_o == '0))
    else $error("inconsistent error result");

  a_components_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> components_left_o != '0)
    else $error("component count reached zero");

endmodule

bind disjoint_set_union_engine dsu_checker u_dsu_checker (.*);
